// ===== rtl/fadd_pkg.sv =====
// ----------------------------------------------------------------------------
// fadd_pkg: shared types and constants
// Field layout of a single word and the pipeline stage records.
// ----------------------------------------------------------------------------
package fadd_pkg;
   localparam int unsigned FRAC_W  = 23;
   localparam int unsigned EXP_W   = 8;
   localparam int unsigned GUARD_W = 7;
   localparam int unsigned MANT_W  = 31;   // hidden one + fraction + guard

   typedef logic [EXP_W-1:0]  exp_type;
   typedef logic [MANT_W-1:0] mant_type;

   // stage 1 -> 2: aligned operands
   typedef struct packed {
      logic     sign_a;
      logic     sign_b;
      exp_type  exp;
      mant_type mant_a;
      mant_type mant_b;
   } align_type;

   // stage 2 -> 3: raw truncated sum
   typedef struct packed {
      logic        sign;
      exp_type     exp;
      logic [24:0] sum;
   } sum_type;
endpackage

// ===== rtl/fadd_norm.sv =====
// ----------------------------------------------------------------------------
// fadd_norm: normalize
// Finds the leading one of the truncated sum and packs the result word.
// ----------------------------------------------------------------------------
module fadd_norm (
   input  fadd_pkg::sum_type in_sum,
   output logic [31:0]       out_word
);
   import fadd_pkg::*;

   logic [4:0]  lead;
   logic [4:0]  lshift;
   logic [23:0] norm;
   exp_type     exp_n;

   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < 25; i++) begin
         if (in_sum.sum[i]) lead = 5'(i);
      end
      lshift = 5'd23 - lead;
      norm   = 24'd0;
      exp_n  = in_sum.exp;
      if (in_sum.sum[24]) begin
         norm  = in_sum.sum[24:1];
         exp_n = in_sum.exp + 8'd1;
      end else begin
         norm  = in_sum.sum[23:0] << lshift;
         exp_n = in_sum.exp - 8'(lshift);
      end
      if (in_sum.sum == 25'd0) out_word = 32'd0;
      else out_word = {in_sum.sign, exp_n, norm[22:0]};
   end
endmodule

// ===== rtl/float32_add_sub.sv =====
// ----------------------------------------------------------------------------
// float32_add_sub: truncating single-precision add/subtract
// Three-stage pipeline: align, add, normalize.
// ----------------------------------------------------------------------------
// Channel  Ports                                          Direction
// request  start/busy, req_operand_a/b, req_operation      in
// response rsp_strobe, rsp_sum_word                        out
//
// One word enters per cycle; busy stays low. Each result passes the align,
// add and normalize registers and shows one cycle wide on rsp_strobe. The
// stages hold the align shifter, the 31-bit adder and the leading-one
// normalizer, one per register stage. Reset clears the stage valid bits
// only. The receiver cannot stall, so the pipeline never holds.
module float32_add_sub (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic        req_operation,
   output logic        rsp_strobe,
   output logic [31:0] rsp_sum_word
);
   import fadd_pkg::*;

   align_type   s1_in, s1_ff;
   sum_type     s2_in, s2_ff;
   logic        v1_ff, v2_ff, v3_ff;
   logic [31:0] word_in, word_ff;

   assign busy = 1'b0;

   // stage 1: unpack, keep the larger exponent, align smaller operand
   always_comb begin
      exp_type  ea, eb;
      mant_type ma, mb;
      logic [7:0] d;
      ea = req_operand_a[30:23];
      eb = req_operand_b[30:23];
      ma = {1'b1, req_operand_a[22:0], 7'd0};
      mb = {1'b1, req_operand_b[22:0], 7'd0};
      s1_in.sign_a = req_operand_a[31];
      s1_in.sign_b = req_operand_b[31] ^ req_operation;
      if (ea < eb) begin
         d = eb - ea;
         ma = (d >= 8'd32) ? '0 : ma >> d[4:0];
         s1_in.exp = eb;
      end else begin
         d = ea - eb;
         mb = (d >= 8'd32) ? '0 : mb >> d[4:0];
         s1_in.exp = ea;
      end
      s1_in.mant_a = ma;
      s1_in.mant_b = mb;
   end

   // stage 2: magnitude compare, add or subtract, drop guard bits
   always_comb begin
      logic [31:0] r;
      logic        ge;
      ge = s1_ff.mant_a >= s1_ff.mant_b;
      if (s1_ff.sign_a ^ s1_ff.sign_b)
         r = ge ? {1'b0, s1_ff.mant_a - s1_ff.mant_b}
                : {1'b0, s1_ff.mant_b - s1_ff.mant_a};
      else
         r = {1'b0, s1_ff.mant_a} + {1'b0, s1_ff.mant_b};
      s2_in.sign = ge ? s1_ff.sign_a : s1_ff.sign_b;
      s2_in.exp  = s1_ff.exp;
      s2_in.sum  = r[31:7];
   end

   // stage 3: normalize
   fadd_norm u_norm (.in_sum(s2_ff), .out_word(word_in));

   always_ff @(posedge clock) begin
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      word_ff <= word_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign rsp_strobe   = v3_ff;
   assign rsp_sum_word = word_ff;
endmodule

// ===== rtl/float32_add_sub_chk.sv =====
// ----------------------------------------------------------------------------
// float32_add_sub_chk: port checker
// Latency, busy and known-result properties seen at the ports.
// ----------------------------------------------------------------------------
module float32_add_sub_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [31:0] rsp_sum_word
);
   a_lat: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_strobe) else $error("lost result");
   a_noinv: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 3)) else $error("invented result");
   a_busy: assert property (@(posedge clock) !busy) else $error("busy set");
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown(rsp_sum_word)) else $error("unknown result word");
endmodule

bind float32_add_sub float32_add_sub_chk u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_sum_word(rsp_sum_word)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// float32_add_sub testbench
// Directed and random add/subtract words through the pipeline. Each result
// is checked against a predicted single word in arrival order.
// ----------------------------------------------------------------------------
module testbench;
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;
   localparam int LIMIT_CYCLES = 200000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_operand_a;
   logic [31:0] req_operand_b;
   logic        req_operation;
   logic        rsp_strobe;
   logic [31:0] rsp_sum_word;

   logic [31:0] sum_queue[$];     // predicted sums, oldest first
   int          error_count;
   int          words_sent;
   int          words_checked;
   int          cycle_count;
   int          idle_percent;     // sender idle chance per cycle

   float32_add_sub i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .req_operation(req_operation),
      .rsp_strobe(rsp_strobe), .rsp_sum_word(rsp_sum_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Truncating add/subtract: hidden one always set, 7 guard bits,
   // exponent wraps mod 256 while normalizing.
   function automatic logic [31:0] predict_sum(logic [31:0] a, logic [31:0] b,
                                               logic op);
      logic        sa, sb, sign;
      logic [7:0]  ea, eb, ex;
      logic [31:0] ma, mb, r;
      logic [8:0]  diff;
      sa = a[31];
      sb = b[31] ^ op;
      ea = a[30:23];
      eb = b[30:23];
      ma = {1'b1, a[22:0]} << 7;
      mb = {1'b1, b[22:0]} << 7;
      if (ea < eb) begin
         diff = eb - ea;
         ma = (diff >= 32) ? 32'd0 : ma >> diff;
         ex = eb;
      end else begin
         diff = ea - eb;
         mb = (diff >= 32) ? 32'd0 : mb >> diff;
         ex = ea;
      end
      if (ma >= mb) begin
         sign = sa;
         r = (sa ^ sb) ? ma - mb : ma + mb;
      end else begin
         sign = sb;
         r = (sa ^ sb) ? mb - ma : mb + ma;
      end
      r = r >> 7;
      if (r == 0) return 32'd0;   // cancellation gives all zeros
      if (r[31:24] != 0) begin
         while (r[31:24] != 0) begin
            ex = ex + 8'd1;
            r = r >> 1;
         end
      end else begin
         while (!r[23]) begin
            ex = ex - 8'd1;
            r = r << 1;
         end
      end
      return {sign, ex, r[22:0]};
   endfunction

   // Send one word; random idle cycles precede it per idle_percent.
   task automatic send_word(logic [31:0] a, logic [31:0] b, logic op);
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      req_operation <= op;
      @(posedge clock);
      while (busy) @(posedge clock);
      sum_queue.push_back(predict_sum(a, b, op));
      words_sent++;
   endtask

   task automatic go_idle();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Sampled at the edge; inputs change by NBA so values are stable here.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (sum_queue.size() == 0) begin
            $error("sum_word: unexpected result %h", rsp_sum_word);
            error_count++;
         end else begin
            logic [31:0] want;
            want = sum_queue.pop_front();
            if (rsp_sum_word !== want) begin
               $error("sum_word: expected %h actual %h", want, rsp_sum_word);
               error_count++;
            end
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("float32_add_sub regression: fail");
         $finish;
      end
   end

   function automatic logic [31:0] random_word();
      return $urandom();
   endfunction

   // Extremes, both operations, large shifts, equal magnitudes, wrap,
   // and exact cancellation.
   task automatic test_directed();
      idle_percent = 0;
      send_word(32'h0000_0000, 32'h0000_0000, OP_ADD);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_ADD);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_SUB);
      send_word(32'h3F80_0000, 32'h3F80_0000, OP_SUB);   // cancels
      send_word(32'h3F80_0000, 32'hBF80_0000, OP_ADD);   // cancels
      send_word(32'h3F80_0000, 32'h3F80_0000, OP_ADD);
      send_word(32'h7F80_0000, 32'h7F80_0000, OP_ADD);   // exponent wraps up
      send_word(32'h0080_0000, 32'h0000_0001, OP_SUB);   // wraps down
      send_word(32'h0000_0000, 32'h0000_0001, OP_SUB);
      send_word(32'h4F80_0000, 32'h3F80_0000, OP_ADD);   // shift 32
      send_word(32'h3F80_0000, 32'h4F00_0000, OP_SUB);   // shift 31
      send_word(32'h3F80_0000, 32'h4F80_0000, OP_ADD);   // b larger, shift 32
      send_word(32'h7F7F_FFFF, 32'h0000_0000, OP_SUB);   // shift 254
      send_word(32'h3FFF_FFFF, 32'h3FFF_FFFE, OP_SUB);
      send_word(32'h3F80_0001, 32'h3F80_0000, OP_SUB);
      send_word(32'h3F80_0000, 32'h3F80_0001, OP_SUB);   // b larger, sign flips
      send_word(32'h4000_0000, 32'h3FFF_FFFF, OP_SUB);   // vanishes in guard
      send_word(32'h8000_0000, 32'h8000_0000, OP_ADD);
      send_word(32'h5555_5555, 32'hAAAA_AAAA, OP_ADD);
      send_word(32'hAAAA_AAAA, 32'h5555_5555, OP_SUB);
      go_idle();
   endtask

   // Random words; exponents often close so that subtraction cancels deep.
   task automatic test_random(int count, int idle);
      logic [31:0] a, b;
      idle_percent = idle;
      repeat (count) begin
         a = random_word();
         b = random_word();
         case ($urandom_range(3))
            0: b[30:23] = a[30:23];
            1: b[30:23] = a[30:23] + 8'($urandom_range(40)) - 8'd20;
            2: b[30:0] = a[30:0] ^ 31'($urandom_range(255));
            default: ;
         endcase
         send_word(a, b, 1'($urandom_range(1)));
      end
      go_idle();
   endtask

   // Let the pipeline drain between phases and at the end.
   task automatic drain();
      while (sum_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      error_count   = 0;
      words_sent    = 0;
      words_checked = 0;
      cycle_count   = 0;
      idle_percent  = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_operand_a = '0;
      req_operand_b = '0;
      req_operation = OP_ADD;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      drain();
      test_random(320, 0);
      test_random(320, 72);
      test_random(310, 33);
      drain();

      $display("Covered %0d words, %0d sums checked, with and without sender gaps.",
               words_sent, words_checked);
      if (error_count == 0) begin
         $display("float32_add_sub regression: pass");
      end else begin
         $display("float32_add_sub regression: fail");
      end
      $finish;
   end
endmodule

// ===== float32_add_sub.f =====
rtl/fadd_pkg.sv
rtl/fadd_norm.sv
rtl/float32_add_sub.sv
rtl/float32_add_sub_chk.sv
tb/sv/testbench.sv
